// File: sv/vdpcs_pkg.sv
// ----------------------------------------------------------------------------
// vdpcs_pkg
// Types and constants shared by the control-port register shadow.
// ----------------------------------------------------------------------------
`default_nettype none

package vdpcs_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned AddrW = 16;

  // Kind of host access seen on the port.
  typedef enum logic {
    ACT_CTRL_WRITE  = 1'b0,
    ACT_STATUS_READ = 1'b1
  } action_t;

  // Register number carried in the low bits of the second control byte.
  typedef enum logic [2:0] {
    REG_CTRL0       = 3'd0,
    REG_CTRL1       = 3'd1,
    REG_NAME        = 3'd2,
    REG_COLOR       = 3'd3,
    REG_PATTERN     = 3'd4,
    REG_SPRITE_ATTR = 3'd5,
    REG_SPRITE_PAT  = 3'd6,
    REG_SCREEN      = 3'd7
  } reg_sel_t;

  // Bit of the second byte that marks a register write.
  localparam int unsigned RegWriteBit = 7;
  // Mode bit in the control word that limits the color and pattern bases.
  localparam int unsigned ModeBit = 1;
  localparam logic [AddrW-1:0] ModeBaseMask = 16'h2000;

  // Left shifts that turn a register byte into a table base address.
  localparam int unsigned NameShift       = 10;
  localparam int unsigned ColorShift      = 6;
  localparam int unsigned PatternShift    = 11;
  localparam int unsigned SpriteAttrShift = 7;
  localparam int unsigned SpritePatShift  = 11;

  // Item held in the input register.
  typedef struct packed {
    logic                 valid;
    action_t              action;
    logic [ByteW-1:0]     port_byte;
  } in_stage_t;

  function automatic logic [AddrW-1:0] scale_base(input logic [ByteW-1:0] v,
                                                  input int unsigned sh);
    logic [AddrW-1:0] wide;
    wide = {{(AddrW-ByteW){1'b0}}, v};
    return wide << sh;
  endfunction

endpackage

`default_nettype wire

// File: sv/vdpcs_if.sv
// ----------------------------------------------------------------------------
// vdpcs_if
// Handshake channels of the control-port register shadow.
// ----------------------------------------------------------------------------
`default_nettype none

interface vdpcs_in_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [7:0] port_byte;

  modport source (output valid, output action, output port_byte, input ready);
  modport sink   (input valid, input action, input port_byte, output ready);
endinterface

interface vdpcs_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] control_word;
  logic [15:0] name_base;
  logic [15:0] color_base;
  logic [15:0] pattern_base;
  logic [15:0] sprite_attr_base;
  logic [15:0] sprite_pat_base;
  logic [7:0]  screen_color;
  logic [7:0]  status_seen;
  logic        second_byte_next;

  modport source (
    output valid, output control_word, output name_base, output color_base,
    output pattern_base, output sprite_attr_base, output sprite_pat_base,
    output screen_color, output status_seen, output second_byte_next,
    input ready
  );
  modport sink (
    input valid, input control_word, input name_base, input color_base,
    input pattern_base, input sprite_attr_base, input sprite_pat_base,
    input screen_color, input status_seen, input second_byte_next,
    output ready
  );
endinterface

`default_nettype wire

// File: sv/vdpcs_in_reg.sv
// ----------------------------------------------------------------------------
// vdpcs_in_reg
// Input register: captures one port access and holds it until the shadow
// update stage takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module vdpcs_in_reg
  import vdpcs_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  vdpcs_in_if.sink    snoop,
  input  wire logic   advance,
  output in_stage_t   stage
);

  // The register refills in the same cycle its item moves on.
  assign snoop.ready = !stage.valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage.valid <= 1'b0;
    end else if (snoop.ready) begin
      stage.valid <= snoop.valid;
    end
    if (snoop.valid && snoop.ready) begin
      stage.action    <= action_t'(snoop.action);
      stage.port_byte <= snoop.port_byte;
    end
  end

endmodule

`default_nettype wire

// File: sv/vdpcs_core.sv
// ----------------------------------------------------------------------------
// vdpcs_core
// Shadow registers, their update logic and the result valid flag. The
// shadow registers themselves are the result presented downstream.
// ----------------------------------------------------------------------------
`default_nettype none

module vdpcs_core
  import vdpcs_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire in_stage_t stage,
  output logic           advance,
  vdpcs_out_if.source    shadow
);

  logic             pair_toggle, pair_toggle_next;
  logic [ByteW-1:0] latched_byte, latched_byte_next;
  logic [AddrW-1:0] control_shadow, control_shadow_next;
  logic [AddrW-1:0] name_shadow, name_shadow_next;
  logic [AddrW-1:0] color_shadow, color_shadow_next;
  logic [AddrW-1:0] pattern_shadow, pattern_shadow_next;
  logic [AddrW-1:0] sprite_attr_shadow, sprite_attr_shadow_next;
  logic [AddrW-1:0] sprite_pat_shadow, sprite_pat_shadow_next;
  logic [ByteW-1:0] screen_shadow, screen_shadow_next;
  logic [ByteW-1:0] status_shadow, status_shadow_next;
  logic             out_valid;

  // The state only moves when the previous result has been taken.
  assign advance = stage.valid && (!out_valid || shadow.ready);

  always_comb begin
    logic [AddrW-1:0] ctrl_tmp;
    logic [AddrW-1:0] color_tmp;
    logic [AddrW-1:0] pattern_tmp;

    pair_toggle_next        = pair_toggle;
    latched_byte_next       = latched_byte;
    name_shadow_next        = name_shadow;
    sprite_attr_shadow_next = sprite_attr_shadow;
    sprite_pat_shadow_next  = sprite_pat_shadow;
    screen_shadow_next      = screen_shadow;
    status_shadow_next      = status_shadow;
    ctrl_tmp                = control_shadow;
    color_tmp               = color_shadow;
    pattern_tmp             = pattern_shadow;

    if (stage.action == ACT_STATUS_READ) begin
      pair_toggle_next   = 1'b0;
      status_shadow_next = stage.port_byte;
    end else begin
      if (pair_toggle) begin
        pair_toggle_next = 1'b0;
        if (stage.port_byte[RegWriteBit]) begin
          case (reg_sel_t'(stage.port_byte[2:0]))
            REG_CTRL0:       ctrl_tmp = {control_shadow[AddrW-1:ByteW], latched_byte};
            REG_CTRL1:       ctrl_tmp = {latched_byte, control_shadow[ByteW-1:0]};
            REG_NAME:        name_shadow_next = scale_base(latched_byte, NameShift);
            REG_COLOR:       color_tmp = scale_base(latched_byte, ColorShift);
            REG_PATTERN:     pattern_tmp = scale_base(latched_byte, PatternShift);
            REG_SPRITE_ATTR: begin
              sprite_attr_shadow_next = scale_base(latched_byte, SpriteAttrShift);
            end
            REG_SPRITE_PAT:  begin
              sprite_pat_shadow_next = scale_base(latched_byte, SpritePatShift);
            end
            REG_SCREEN:      screen_shadow_next = latched_byte;
            default:         screen_shadow_next = screen_shadow;
          endcase
        end
      end else begin
        pair_toggle_next  = 1'b1;
        latched_byte_next = stage.port_byte;
      end
      // The mode check uses the control word as it stands after this write.
      if (ctrl_tmp[ModeBit]) begin
        color_tmp   = color_tmp & ModeBaseMask;
        pattern_tmp = pattern_tmp & ModeBaseMask;
      end
    end

    control_shadow_next = ctrl_tmp;
    color_shadow_next   = color_tmp;
    pattern_shadow_next = pattern_tmp;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pair_toggle        <= 1'b0;
      latched_byte       <= '0;
      control_shadow     <= '0;
      name_shadow        <= '0;
      color_shadow       <= '0;
      pattern_shadow     <= '0;
      sprite_attr_shadow <= '0;
      sprite_pat_shadow  <= '0;
      screen_shadow      <= '0;
      status_shadow      <= '0;
    end else if (advance) begin
      pair_toggle        <= pair_toggle_next;
      latched_byte       <= latched_byte_next;
      control_shadow     <= control_shadow_next;
      name_shadow        <= name_shadow_next;
      color_shadow       <= color_shadow_next;
      pattern_shadow     <= pattern_shadow_next;
      sprite_attr_shadow <= sprite_attr_shadow_next;
      sprite_pat_shadow  <= sprite_pat_shadow_next;
      screen_shadow      <= screen_shadow_next;
      status_shadow      <= status_shadow_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (shadow.ready) begin
      out_valid <= 1'b0;
    end
  end

  assign shadow.valid            = out_valid;
  assign shadow.control_word     = control_shadow;
  assign shadow.name_base        = name_shadow;
  assign shadow.color_base       = color_shadow;
  assign shadow.pattern_base     = pattern_shadow;
  assign shadow.sprite_attr_base = sprite_attr_shadow;
  assign shadow.sprite_pat_base  = sprite_pat_shadow;
  assign shadow.screen_color     = screen_shadow;
  assign shadow.status_seen      = status_shadow;
  assign shadow.second_byte_next = pair_toggle;

endmodule

`default_nettype wire

// File: sv/vdp_control_port_shadow.sv
// ----------------------------------------------------------------------------
// vdp_control_port_shadow
// Watches host accesses to a video display processor's control port and
// keeps a shadow of its eight write-only registers.
// ----------------------------------------------------------------------------
//   channel   role     contents
//   snoop     sink     action (write / status read), port_byte
//   shadow    source   control word, five table bases, screen color,
//                      last status, pair toggle
//
// An access is registered on entry and the shadow registers are updated when
// it moves on from the input register, which sets the result valid; one
// item is taken every cycle while shadow is ready. The input register and the
// shadow registers each hold one item; a stall on shadow backs up into snoop.
// Reset (rst, synchronous) clears every shadow register and the pair toggle.
// ----------------------------------------------------------------------------
`default_nettype none

module vdp_control_port_shadow
  import vdpcs_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  vdpcs_in_if.sink    snoop,
  vdpcs_out_if.source shadow
);

  in_stage_t stage;
  logic      advance;

  vdpcs_in_reg u_in_reg (
    .clk     (clk),
    .rst     (rst),
    .snoop   (snoop),
    .advance (advance),
    .stage   (stage)
  );

  vdpcs_core u_core (
    .clk     (clk),
    .rst     (rst),
    .stage   (stage),
    .advance (advance),
    .shadow  (shadow)
  );

endmodule

`default_nettype wire

// File: sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the control-port register shadow. Host accesses
// (control writes and status reads) are sent in pairs and as noise, with
// random gaps and output stalls. A shadow tracker predicts every result item
// and compares it field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
  import vdpcs_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RandomAccesses = 1100;
  localparam int unsigned QuietTail      = 150;

  typedef struct packed {
    logic [15:0] control_word;
    logic [15:0] name_base;
    logic [15:0] color_base;
    logic [15:0] pattern_base;
    logic [15:0] sprite_attr_base;
    logic [15:0] sprite_pat_base;
    logic [7:0]  screen_color;
    logic [7:0]  status_seen;
    logic        second_byte_next;
  } shadow_view_t;

  // Tracks the register shadow and holds the views still to come out.
  class vdp_shadow_tracker;
    logic             pair_toggle;
    logic [7:0]       latched_byte;
    shadow_view_t     view;
    shadow_view_t     expected_views[$];
    int unsigned      mismatches;
    int unsigned      n_stores;
    int unsigned      n_setups;
    int unsigned      n_status;
    int unsigned      n_checked;

    function new();
      pair_toggle  = 1'b0;
      latched_byte = '0;
      view         = '0;
      mismatches   = 0;
      n_stores     = 0;
      n_setups     = 0;
      n_status     = 0;
      n_checked    = 0;
    endfunction

    function void store_latched(input reg_sel_t sel);
      logic [15:0] wide;
      wide = {8'h00, latched_byte};
      case (sel)
        REG_CTRL0:       view.control_word[7:0]  = latched_byte;
        REG_CTRL1:       view.control_word[15:8] = latched_byte;
        REG_NAME:        view.name_base          = wide << NameShift;
        REG_COLOR:       view.color_base         = wide << ColorShift;
        REG_PATTERN:     view.pattern_base       = wide << PatternShift;
        REG_SPRITE_ATTR: view.sprite_attr_base   = wide << SpriteAttrShift;
        REG_SPRITE_PAT:  view.sprite_pat_base    = wide << SpritePatShift;
        default:         view.screen_color       = latched_byte;
      endcase
    endfunction

    function void note_access(input action_t act, input logic [7:0] b);
      if (act == ACT_STATUS_READ) begin
        pair_toggle      = 1'b0;
        view.status_seen = b;
        n_status++;
      end else begin
        if (pair_toggle) begin
          if (b[RegWriteBit]) begin
            store_latched(reg_sel_t'(b[2:0]));
            n_stores++;
          end else begin
            n_setups++;
          end
          pair_toggle = 1'b0;
        end else begin
          pair_toggle  = 1'b1;
          latched_byte = b;
        end
        // The mode check runs after every control write, first byte included.
        if (view.control_word[ModeBit]) begin
          view.color_base   = view.color_base & ModeBaseMask;
          view.pattern_base = view.pattern_base & ModeBaseMask;
        end
      end
      view.second_byte_next = pair_toggle;
      expected_views.push_back(view);
    endfunction

    function void compare_field(input string name, input logic [15:0] exp_v,
                                input logic [15:0] act_v);
      if (exp_v !== act_v) begin
        $error("%s: expected %h, actual %h", name, exp_v, act_v);
        mismatches++;
      end
    endfunction

    function void check_result(input shadow_view_t got);
      shadow_view_t exp_v;
      if (expected_views.size() == 0) begin
        $error("result item with nothing expected: %p", got);
        mismatches++;
        return;
      end
      exp_v = expected_views.pop_front();
      n_checked++;
      compare_field("control_word", exp_v.control_word, got.control_word);
      compare_field("name_base", exp_v.name_base, got.name_base);
      compare_field("color_base", exp_v.color_base, got.color_base);
      compare_field("pattern_base", exp_v.pattern_base, got.pattern_base);
      compare_field("sprite_attr_base", exp_v.sprite_attr_base, got.sprite_attr_base);
      compare_field("sprite_pat_base", exp_v.sprite_pat_base, got.sprite_pat_base);
      compare_field("screen_color", {8'h00, exp_v.screen_color},
                    {8'h00, got.screen_color});
      compare_field("status_seen", {8'h00, exp_v.status_seen},
                    {8'h00, got.status_seen});
      compare_field("second_byte_next", {15'h0, exp_v.second_byte_next},
                    {15'h0, got.second_byte_next});
    endfunction

    function int unsigned pending();
      return expected_views.size();
    endfunction
  endclass

  logic clk;
  logic rst;

  vdpcs_in_if  snoop_if ();
  vdpcs_out_if shadow_if ();

  vdp_control_port_shadow i_dut (
    .clk    (clk),
    .rst    (rst),
    .snoop  (snoop_if),
    .shadow (shadow_if)
  );

  vdp_shadow_tracker tracker;
  bit                quiet;
  bit                gaps_on;
  int unsigned       sent;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  // Accepted accesses feed the tracker; accepted results are checked.
  always @(posedge clk) begin
    if (!rst && snoop_if.valid && snoop_if.ready) begin
      tracker.note_access(action_t'(snoop_if.action), snoop_if.port_byte);
    end
    if (!rst && shadow_if.valid && shadow_if.ready) begin
      tracker.check_result('{
        control_word:     shadow_if.control_word,
        name_base:        shadow_if.name_base,
        color_base:       shadow_if.color_base,
        pattern_base:     shadow_if.pattern_base,
        sprite_attr_base: shadow_if.sprite_attr_base,
        sprite_pat_base:  shadow_if.sprite_pat_base,
        screen_color:     shadow_if.screen_color,
        status_seen:      shadow_if.status_seen,
        second_byte_next: shadow_if.second_byte_next
      });
    end
  end

  // Result side: ready stretches of varying length broken by short stalls.
  initial begin
    shadow_if.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      shadow_if.ready <= 1'b1;
      if (quiet) begin
        @(posedge clk);
      end else begin
        if ($urandom_range(0, 3) == 0) begin
          repeat ($urandom_range(20, 60)) @(posedge clk);
        end else begin
          repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        if (!quiet) begin
          shadow_if.ready <= 1'b0;
          repeat ($urandom_range(1, 10)) @(posedge clk);
        end
      end
    end
  end

  // Valid stays high across back-to-back items; it drops only for a gap.
  task automatic send_access(input action_t act, input logic [7:0] b);
    snoop_if.valid     <= 1'b1;
    snoop_if.action    <= act;
    snoop_if.port_byte <= b;
    do @(posedge clk); while (!snoop_if.ready);
    sent++;
    if (!quiet && gaps_on && $urandom_range(0, 3) == 0) begin
      snoop_if.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
  endtask

  task automatic send_pair(input logic [7:0] first_b, input logic [7:0] second_b);
    send_access(ACT_CTRL_WRITE, first_b);
    send_access(ACT_CTRL_WRITE, second_b);
  endtask

  initial begin
    int unsigned pick;
    reg_sel_t    sel;

    tracker = new();
    quiet   = 1'b0;
    gaps_on = 1'b1;
    sent    = 0;

    rst                <= 1'b1;
    snoop_if.valid     <= 1'b0;
    snoop_if.action    <= ACT_CTRL_WRITE;
    snoop_if.port_byte <= 8'h00;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part: status extremes, all-ones data to control byte 0 and, with
    // the ignored select bits set, to the name through screen registers, an
    // address setup, a status read that breaks a pair, and the mode bit masking the color and pattern bases.
    send_access(ACT_STATUS_READ, 8'hFF);
    send_access(ACT_STATUS_READ, 8'h00);
    send_pair(8'hFF, {1'b1, 4'b0000, REG_CTRL0});
    for (int r = REG_NAME; r <= REG_SCREEN; r++) begin
      sel = reg_sel_t'(r);
      send_pair(8'hFF, {1'b1, 4'b1111, sel});
    end
    send_pair(8'h00, 8'h7F);
    send_access(ACT_CTRL_WRITE, 8'h55);
    send_access(ACT_STATUS_READ, 8'hA5);
    send_pair(8'h02, {1'b1, 4'b0000, REG_CTRL1});
    send_pair(8'hFF, {1'b1, 4'b0000, REG_PATTERN});
    send_pair(8'h00, {1'b1, 4'b0000, REG_CTRL1});

    // Random part: mostly well-formed register stores with random content,
    // plus address setups, status reads, broken pairs and stray bytes.
    while (sent < RandomAccesses + 26) begin
      if (sent >= RandomAccesses + 26 - QuietTail) quiet = 1'b1;
      if ($urandom_range(0, 49) == 0) gaps_on = !gaps_on;
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
        send_pair(8'($urandom), {1'b1, 4'($urandom), 3'($urandom)});
      end else if (pick < 65) begin
        send_pair(8'($urandom), {1'b0, 7'($urandom)});
      end else if (pick < 80) begin
        send_access(ACT_STATUS_READ, 8'($urandom));
      end else if (pick < 90) begin
        send_access(ACT_CTRL_WRITE, 8'($urandom));
        send_access(ACT_STATUS_READ, 8'($urandom));
      end else begin
        send_access(ACT_CTRL_WRITE, 8'($urandom));
      end
    end
    snoop_if.valid <= 1'b0;

    while (tracker.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Sent %0d accesses: %0d register stores, %0d address setups, %0d status reads.",
             sent, tracker.n_stores, tracker.n_setups, tracker.n_status);
    $display("Compared %0d shadow results, %0d mismatches.",
             tracker.n_checked, tracker.mismatches);
    if (tracker.mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
